FILE: rtl/brt_pkg.sv
package brt_pkg;

	localparam int TIME_BITS = 32;
	localparam int CHARGE_BITS = 24;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int TIME_EXT = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int DW = TIME_EXT + 2;
	localparam int CD_W = 46;
	localparam int AX_W = 30;
	localparam int Z_W = 20;
	localparam int CX_W = 50;
	localparam int ACC_W = 24;
	localparam int SQ_N = 64;
	localparam int SQ_R = 32;
	localparam int SQ_REM = SQ_R + 3;
	localparam int SQ_CELLS = SQ_R;
	localparam int STEP_W = $clog2(SQ_CELLS);
	localparam int CORDIC_STEPS = 20;
	localparam int WINDOW_PAD = 5120;
	localparam int PATH_W = 20;
	localparam int ANGLE_W = 15;
	localparam int PATH_MAX = 1048575;
	localparam int ANGLE_MAX = 25736;
	localparam logic [1:0] BAR_UNKNOWN = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAR_TYPE = 3'd0,
		REG_TIME_OFFSET = 3'd1,
		REG_Z0_DISTANCE = 3'd2,
		REG_X_OFFSET = 3'd3,
		REG_LIGHT_SPEED = 3'd4,
		REG_LENGTH_TIME = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] bar_type;
		logic signed [31:0] time_offset;
		logic [15:0] z0_distance;
		logic signed [15:0] x_offset;
		logic [15:0] light_speed;
		logic [23:0] length_time;
	} cfg_t;

	typedef struct packed {
		logic signed [TIME_BITS-1:0] left_time;
		logic signed [TIME_BITS-1:0] right_time;
		logic signed [TIME_BITS-1:0] left_walk_time;
		logic signed [TIME_BITS-1:0] right_walk_time;
		logic [CHARGE_BITS-1:0] left_charge;
		logic [CHARGE_BITS-1:0] right_charge;
	} in_t;

	typedef struct packed {
		logic signed [TIME_BITS-1:0] time_diff;
		logic signed [TIME_BITS-1:0] time_avg;
		logic signed [TIME_BITS-1:0] walk_time_diff;
		logic signed [TIME_BITS-1:0] walk_time_avg;
		logic [CHARGE_BITS-1:0] charge_mean;
		logic [PATH_W-1:0] flight_path;
		logic [ANGLE_W-1:0] hit_angle;
		logic has_event;
		logic path_valid;
	} out_t;

	typedef struct packed {
		logic signed [TIME_BITS-1:0] time_diff;
		logic signed [TIME_BITS-1:0] time_avg;
		logic signed [TIME_BITS-1:0] walk_time_diff;
		logic signed [TIME_BITS-1:0] walk_time_avg;
		logic has_event;
		logic known;
	} side_t;

	typedef struct packed {
		logic [SQ_N-1:0] n;
		logic [SQ_REM-1:0] rem;
		logic [SQ_R-1:0] root;
	} sq_t;

	typedef struct packed {
		sq_t path;
		sq_t charge;
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [ACC_W-1:0] acc;
		side_t side;
	} cell_t;

	function automatic logic signed [ACC_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [ACC_W-1:0] v;
		case (i)
			5'd0: v = 24'sd823550;
			5'd1: v = 24'sd486170;
			5'd2: v = 24'sd256879;
			5'd3: v = 24'sd130396;
			5'd4: v = 24'sd65451;
			5'd5: v = 24'sd32757;
			5'd6: v = 24'sd16383;
			5'd7: v = 24'sd8192;
			5'd8: v = 24'sd4096;
			5'd9: v = 24'sd2048;
			5'd10: v = 24'sd1024;
			5'd11: v = 24'sd512;
			5'd12: v = 24'sd256;
			5'd13: v = 24'sd128;
			5'd14: v = 24'sd64;
			5'd15: v = 24'sd32;
			5'd16: v = 24'sd16;
			5'd17: v = 24'sd8;
			5'd18: v = 24'sd4;
			5'd19: v = 24'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/brt_front.sv
module brt_front (
	input logic clk,
	input logic en,
	input brt_pkg::in_t in_data,
	input brt_pkg::cfg_t cfg,
	output brt_pkg::cell_t head
);

	localparam int DW_L = brt_pkg::DW;
	localparam logic signed [DW_L-1:0] T_HI = DW_L'((64'sd1 <<< (brt_pkg::TIME_BITS - 1)) - 64'sd1);
	localparam logic signed [DW_L-1:0] T_LO = -T_HI - DW_L'(1);
	localparam logic signed [63:0] D_LIM = 64'sd1 <<< 44;

	logic signed [DW_L-1:0] d, wd;
	logic signed [brt_pkg::TIME_BITS:0] tsum, wsum;
	logic [DW_L-1:0] ad;
	logic signed [63:0] d64;
	logic signed [63:0] x_val;
	logic [63:0] mag;
	logic [63:0] ax_full;
	brt_pkg::side_t side_c;

	brt_pkg::side_t side_s1, side_s2, side_s3;
	logic signed [brt_pkg::CD_W-1:0] cd_s1;
	logic [2*brt_pkg::CHARGE_BITS-1:0] qprod_s1, qprod_s2, qprod_s3;
	logic signed [63:0] x_s2;
	logic [brt_pkg::AX_W-1:0] ax_s3;
	logic [brt_pkg::Z_W-1:0] z_s3;

	always_comb begin
		d = DW_L'(in_data.left_time) - DW_L'(in_data.right_time) + DW_L'(cfg.time_offset);
		wd = DW_L'(in_data.left_walk_time) - DW_L'(in_data.right_walk_time)
			+ DW_L'(cfg.time_offset);
		tsum = (brt_pkg::TIME_BITS+1)'(in_data.left_time)
			+ (brt_pkg::TIME_BITS+1)'(in_data.right_time);
		wsum = (brt_pkg::TIME_BITS+1)'(in_data.left_walk_time)
			+ (brt_pkg::TIME_BITS+1)'(in_data.right_walk_time);
		ad = d[DW_L-1] ? DW_L'(-d) : DW_L'(d);
		side_c.time_diff = (d > T_HI) ? T_HI[brt_pkg::TIME_BITS-1:0] :
			(d < T_LO) ? T_LO[brt_pkg::TIME_BITS-1:0] : d[brt_pkg::TIME_BITS-1:0];
		side_c.walk_time_diff = (wd > T_HI) ? T_HI[brt_pkg::TIME_BITS-1:0] :
			(wd < T_LO) ? T_LO[brt_pkg::TIME_BITS-1:0] : wd[brt_pkg::TIME_BITS-1:0];
		side_c.time_avg = tsum[brt_pkg::TIME_BITS:1];
		side_c.walk_time_avg = wsum[brt_pkg::TIME_BITS:1];
		side_c.has_event = 64'(ad) < (64'(cfg.length_time) + 64'(brt_pkg::WINDOW_PAD));
		side_c.known = cfg.bar_type != brt_pkg::BAR_UNKNOWN;
		d64 = 64'(d);
		if (d64 > D_LIM) begin
			d64 = D_LIM;
		end else if (d64 < -D_LIM) begin
			d64 = -D_LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			cd_s1 <= d64[brt_pkg::CD_W-1:0];
			qprod_s1 <= (2*brt_pkg::CHARGE_BITS)'(in_data.left_charge)
				* (2*brt_pkg::CHARGE_BITS)'(in_data.right_charge);
		end
	end

	always_comb begin
		x_val = 64'(signed'({1'b0, cfg.light_speed}) * cd_s1) + (64'(cfg.x_offset) <<< 13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			qprod_s2 <= qprod_s1;
			x_s2 <= x_val;
		end
	end

	always_comb begin
		mag = x_s2[63] ? 64'(-x_s2) : 64'(x_s2);
		ax_full = (mag + 64'd256) >> 9;
		if (ax_full > (64'd1 << 29)) begin
			ax_full = 64'd1 << 29;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			qprod_s3 <= qprod_s2;
			ax_s3 <= ax_full[brt_pkg::AX_W-1:0];
			z_s3 <= {cfg.z0_distance, 4'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head.side <= side_s3;
			head.path.n <= 64'(ax_s3) * 64'(ax_s3) + 64'(z_s3) * 64'(z_s3);
			head.path.rem <= '0;
			head.path.root <= '0;
			head.charge.n <= brt_pkg::SQ_N'(qprod_s3);
			head.charge.rem <= '0;
			head.charge.root <= '0;
			head.cx <= brt_pkg::CX_W'({z_s3, 16'd0});
			head.cy <= brt_pkg::CX_W'({ax_s3, 16'd0});
			head.acc <= '0;
		end
	end

endmodule

FILE: rtl/brt_cell.sv
module brt_cell (
	input logic clk,
	input logic en,
	input logic [brt_pkg::STEP_W-1:0] step,
	input brt_pkg::cell_t d,
	output brt_pkg::cell_t q
);

	function automatic brt_pkg::sq_t sqrt_step(input brt_pkg::sq_t s);
		brt_pkg::sq_t r;
		logic [brt_pkg::SQ_REM-1:0] rem2, trial;
		rem2 = {s.rem[brt_pkg::SQ_REM-3:0], s.n[brt_pkg::SQ_N-1 -: 2]};
		trial = brt_pkg::SQ_REM'({s.root, 2'b01});
		r.n = s.n << 2;
		if (rem2 >= trial) begin
			r.rem = rem2 - trial;
			r.root = {s.root[brt_pkg::SQ_R-2:0], 1'b1};
		end else begin
			r.rem = rem2;
			r.root = {s.root[brt_pkg::SQ_R-2:0], 1'b0};
		end
		return r;
	endfunction

	brt_pkg::cell_t nxt;
	logic signed [brt_pkg::CX_W-1:0] sx, sy;

	always_comb begin
		nxt = d;
		nxt.path = sqrt_step(d.path);
		nxt.charge = sqrt_step(d.charge);
		sx = d.cx >>> step;
		sy = d.cy >>> step;
		if (32'(step) < brt_pkg::CORDIC_STEPS) begin
			if (d.cy > 0) begin
				nxt.cx = d.cx + sy;
				nxt.cy = d.cy - sx;
				nxt.acc = d.acc + brt_pkg::atan_step(step);
			end else begin
				nxt.cx = d.cx - sy;
				nxt.cy = d.cy + sx;
				nxt.acc = d.acc - brt_pkg::atan_step(step);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

FILE: rtl/bar_detector_event_reconstruct_core.sv
// Fully pipelined bar hit reconstruction: one transaction in and one out per cycle while
// the output is taken. Four front stages form the time differences, means, event window
// and the position along the bar, then a row of 32 cells each resolves one bit of both
// square roots and, in the first 20, one CORDIC rotation for the angle; a final stage
// rounds and saturates, and an output register with a skid stage keeps the input side
// open while one result waits, closing it only once the skid stage is full.
module bar_detector_event_reconstruct_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input brt_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output brt_pkg::out_t out_data,
	input logic cfg_we,
	input logic [brt_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [brt_pkg::CFG_W-1:0] cfg_data
);

	localparam int PIPE = 4 + brt_pkg::SQ_CELLS + 1;

	brt_pkg::cfg_t cfg_q;
	logic [PIPE-1:0] vld_q;
	logic adv;
	brt_pkg::cell_t chain [brt_pkg::SQ_CELLS+1];
	brt_pkg::cell_t tail;
	brt_pkg::out_t fin_c, fin_q, skid_q, out_q;
	logic skid_v_q, out_v_q;
	logic signed [brt_pkg::ACC_W-1:0] a_pos;
	logic [brt_pkg::ACC_W-1:0] a_rnd;
	logic [brt_pkg::SQ_R:0] p_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				brt_pkg::REG_BAR_TYPE: cfg_q.bar_type <= cfg_data[1:0];
				brt_pkg::REG_TIME_OFFSET: cfg_q.time_offset <= cfg_data[31:0];
				brt_pkg::REG_Z0_DISTANCE: cfg_q.z0_distance <= cfg_data[15:0];
				brt_pkg::REG_X_OFFSET: cfg_q.x_offset <= cfg_data[15:0];
				brt_pkg::REG_LIGHT_SPEED: cfg_q.light_speed <= cfg_data[15:0];
				brt_pkg::REG_LENGTH_TIME: cfg_q.length_time <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign adv = !skid_v_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE-2:0], in_valid};
		end
	end

	brt_front u_front (
		.clk(clk),
		.en(adv),
		.in_data(in_data),
		.cfg(cfg_q),
		.head(chain[0])
	);

	for (genvar i = 0; i < brt_pkg::SQ_CELLS; i++) begin : g_cell
		brt_cell u_cell (
			.clk(clk),
			.en(adv),
			.step(brt_pkg::STEP_W'(i)),
			.d(chain[i]),
			.q(chain[i+1])
		);
	end

	assign tail = chain[brt_pkg::SQ_CELLS];

	always_comb begin
		a_pos = (tail.acc < 0) ? '0 : tail.acc;
		a_rnd = (brt_pkg::ACC_W'(a_pos) + brt_pkg::ACC_W'(32)) >> 6;
		p_rnd = ((brt_pkg::SQ_R+1)'(tail.path.root) + (brt_pkg::SQ_R+1)'(8)) >> 4;
		fin_c.time_diff = tail.side.time_diff;
		fin_c.time_avg = tail.side.time_avg;
		fin_c.walk_time_diff = tail.side.walk_time_diff;
		fin_c.walk_time_avg = tail.side.walk_time_avg;
		fin_c.charge_mean = tail.charge.root[brt_pkg::CHARGE_BITS-1:0];
		fin_c.path_valid = tail.side.known;
		fin_c.has_event = tail.side.known && tail.side.has_event;
		fin_c.flight_path = '0;
		fin_c.hit_angle = '0;
		if (tail.side.known) begin
			fin_c.flight_path = (p_rnd > (brt_pkg::SQ_R+1)'(brt_pkg::PATH_MAX)) ?
				brt_pkg::PATH_W'(brt_pkg::PATH_MAX) : p_rnd[brt_pkg::PATH_W-1:0];
			fin_c.hit_angle = (a_rnd > brt_pkg::ACC_W'(brt_pkg::ANGLE_MAX)) ?
				brt_pkg::ANGLE_W'(brt_pkg::ANGLE_MAX) : a_rnd[brt_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_q <= fin_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_q[PIPE-1];
			end
		end else if (vld_q[PIPE-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : fin_q;
		end else if (vld_q[PIPE-1] && adv) begin
			skid_q <= fin_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid stage holds a transaction ahead of output");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0]) else $error("accepted transaction lost");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hit_angle <= brt_pkg::ANGLE_W'(brt_pkg::ANGLE_MAX))
		else $error("angle beyond range");

	a_unknown_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.path_valid) |-> (out_data.flight_path == '0
		&& out_data.hit_angle == '0 && !out_data.has_event))
		else $error("unknown bar type result not cleared");

endmodule
